>>> src/blfc_pkg.sv
`timescale 1ns / 1ps

package blfc_pkg;

    localparam int THR_W      = 14;
    localparam int TMO_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;
    localparam int ACCEL_W    = 13;
    localparam int SUM_W      = ACCEL_W + 2;
    localparam int PIXEL_W    = 5;
    localparam int COLOR_W    = 8;
    localparam int NOTIFY_W   = 2;
    // wide enough for any strip of up to 64 pixels
    localparam int BAR_W      = 6;

    localparam logic [THR_W-1:0] THR_RESET = 14'd2000;
    localparam logic [TMO_W-1:0] TMO_RESET = 16'd5000;

    typedef enum logic
    {
        CFG_THRESHOLD = 1'b0,
        CFG_TIMEOUT   = 1'b1
    } cfg_index_t;

    localparam int NOTIFY_TRIG_BIT = 0;
    localparam int NOTIFY_END_BIT  = 1;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;
    localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'h00;
    localparam logic [COLOR_W-1:0] AMBER_R    = 8'hFF;
    localparam logic [COLOR_W-1:0] AMBER_G    = 8'hBF;
    localparam logic [COLOR_W-1:0] AMBER_B    = 8'h00;

    localparam int LAMP_SPAN = 3;
    localparam int BAR_LOW   = 3;
    localparam int BAR_MARGIN = 5;

    typedef struct packed
    {
        logic                panic;
        logic                flash_on;
        logic                left_blink;
        logic                right_blink;
        logic [BAR_W-1:0]    draw_bar;
        logic                left_lamp;
        logic                right_lamp;
        logic [NOTIFY_W-1:0] notify;
    } frame_desc_t;

endpackage

>>> src/blfc_front.sv
`timescale 1ns / 1ps

module blfc_front #(
    parameter int NUM_PIXELS   = 20,
    parameter int FLASH_PERIOD = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  blfc_pkg::cfg_index_t              cfg_index,
    input  logic [blfc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              accept,
    input  logic [blfc_pkg::TIME_W-1:0]       time_ms,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_x,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_y,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_z,
    input  logic                              right_button_n,
    input  logic                              left_button_n,
    output blfc_pkg::frame_desc_t             desc
);
    import blfc_pkg::*;

    localparam int PIX_W = $clog2(NUM_PIXELS);
    localparam int FL_W  = $clog2(FLASH_PERIOD);

    logic [THR_W-1:0]  thr_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic              panic_reg, panic_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic              right_prev_reg, left_prev_reg;
    logic              right_blink_reg, right_blink_next;
    logic              left_blink_reg, left_blink_next;
    logic [FL_W-1:0]   phase_reg, phase_next;
    logic [PIX_W-1:0]  bar_reg, bar_next;
    logic              rev_reg, rev_next;
    logic              left_lamp_reg, left_lamp_next;
    logic              right_lamp_reg, right_lamp_next;

    logic [ACCEL_W-1:0] abs_x, abs_y, abs_z;
    logic [SUM_W-1:0]   sum;
    logic [TIME_W-1:0]  elapsed;
    logic               trig, ends, flash_on, right_press, left_press;

    function automatic logic [ACCEL_W-1:0] abs_val(input logic [ACCEL_W-1:0] v);
        return v[ACCEL_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        abs_x = abs_val(accel_x);
        abs_y = abs_val(accel_y);
        abs_z = abs_val(accel_z);
        sum = SUM_W'(abs_x) + SUM_W'(abs_y) + SUM_W'(abs_z);
        trig = sum > SUM_W'(thr_reg);
        elapsed = time_ms - start_reg;
        ends = panic_reg && !trig && (elapsed > TIME_W'(tmo_reg));
        panic_next = trig | (panic_reg & ~ends);
        start_next = trig ? time_ms : start_reg;

        right_press = !right_button_n;
        left_press = !left_button_n;
        right_blink_next = right_blink_reg ^ (right_press & ~right_prev_reg);
        left_blink_next = left_blink_reg ^ (left_press & ~left_prev_reg);

        flash_on = phase_reg >= FL_W'(FLASH_PERIOD / 2);
        phase_next = (phase_reg == FL_W'(FLASH_PERIOD - 1)) ? '0 : phase_reg + 1'b1;

        left_lamp_next = left_lamp_reg;
        right_lamp_next = right_lamp_reg;
        bar_next = bar_reg;
        rev_next = rev_reg;
        if (!panic_next)
        begin
            left_lamp_next = left_blink_next & flash_on;
            right_lamp_next = right_blink_next & flash_on;
            if (!rev_reg && bar_reg == PIX_W'(NUM_PIXELS - BAR_MARGIN))
                rev_next = 1'b1;
            else if (rev_reg && bar_reg == PIX_W'(BAR_LOW))
                rev_next = 1'b0;
            bar_next = rev_next ? bar_reg - 1'b1 : bar_reg + 1'b1;
        end

        desc.panic = panic_next;
        desc.flash_on = flash_on;
        desc.left_blink = left_blink_next;
        desc.right_blink = right_blink_next;
        desc.draw_bar = BAR_W'(bar_reg);
        desc.left_lamp = left_lamp_next;
        desc.right_lamp = right_lamp_next;
        desc.notify = '0;
        desc.notify[NOTIFY_TRIG_BIT] = trig;
        desc.notify[NOTIFY_END_BIT] = ends;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            tmo_reg <= TMO_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                CFG_TIMEOUT:   tmo_reg <= cfg_data[TMO_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panic_reg       <= 1'b0;
            start_reg       <= '0;
            right_prev_reg  <= 1'b0;
            left_prev_reg   <= 1'b0;
            right_blink_reg <= 1'b0;
            left_blink_reg  <= 1'b0;
            phase_reg       <= '0;
            bar_reg         <= PIX_W'(BAR_LOW);
            rev_reg         <= 1'b0;
            left_lamp_reg   <= 1'b0;
            right_lamp_reg  <= 1'b0;
        end
        else if (accept)
        begin
            panic_reg       <= panic_next;
            start_reg       <= start_next;
            right_prev_reg  <= right_press;
            left_prev_reg   <= left_press;
            right_blink_reg <= right_blink_next;
            left_blink_reg  <= left_blink_next;
            phase_reg       <= phase_next;
            bar_reg         <= bar_next;
            rev_reg         <= rev_next;
            left_lamp_reg   <= left_lamp_next;
            right_lamp_reg  <= right_lamp_next;
        end
    end

endmodule

>>> src/blfc_queue.sv
`timescale 1ns / 1ps

module blfc_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  blfc_pkg::frame_desc_t push_desc,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output blfc_pkg::frame_desc_t head_desc
);
    import blfc_pkg::*;

    frame_desc_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        full = count_reg == 2'd2;
        not_empty = count_reg != 2'd0;
        head_desc = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/blfc_back.sv
`timescale 1ns / 1ps

module blfc_back #(
    parameter int NUM_PIXELS = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_not_empty,
    input  blfc_pkg::frame_desc_t           q_desc,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [blfc_pkg::PIXEL_W-1:0]    pixel_index,
    output logic [blfc_pkg::COLOR_W-1:0]    red,
    output logic [blfc_pkg::COLOR_W-1:0]    green,
    output logic [blfc_pkg::COLOR_W-1:0]    blue,
    output logic                            last_pixel,
    output logic                            panic_active,
    output logic                            left_lamp,
    output logic                            right_lamp,
    output logic [blfc_pkg::NOTIFY_W-1:0]   notify
);
    import blfc_pkg::*;

    localparam int PIX_W = $clog2(NUM_PIXELS);

    logic [PIX_W-1:0]    cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic [PIXEL_W-1:0]  index_reg;
    logic [COLOR_W-1:0]  red_reg, green_reg, blue_reg;
    logic                last_reg, panic_reg, llamp_reg, rlamp_reg;
    logic [NOTIFY_W-1:0] notify_reg;

    logic               load, emit, is_last;
    logic [BAR_W-1:0]   pos;
    logic [COLOR_W-1:0] r, g, b;

    always_comb
    begin
        load = !valid_reg || !out_stall;
        emit = load && q_not_empty;
        is_last = cnt_reg == PIX_W'(NUM_PIXELS - 1);
        q_pop = emit && is_last;
        valid_next = load ? q_not_empty : valid_reg;
        cnt_next = cnt_reg;
        if (emit)
            cnt_next = is_last ? '0 : cnt_reg + 1'b1;

        pos = BAR_W'(cnt_reg);
        r = COLOR_OFF;
        g = COLOR_OFF;
        b = COLOR_OFF;
        if (q_desc.panic)
        begin
            if (q_desc.flash_on)
                r = COLOR_FULL;
        end
        else
        begin
            if ((q_desc.left_blink && q_desc.flash_on &&
                 pos >= BAR_W'(NUM_PIXELS - LAMP_SPAN)) ||
                (q_desc.right_blink && q_desc.flash_on && pos < BAR_W'(LAMP_SPAN)))
            begin
                r = AMBER_R;
                g = AMBER_G;
                b = AMBER_B;
            end
            if (pos == q_desc.draw_bar || pos == q_desc.draw_bar + 1'b1)
            begin
                r = COLOR_FULL;
                g = COLOR_OFF;
                b = COLOR_OFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            index_reg  <= PIXEL_W'(cnt_reg);
            red_reg    <= r;
            green_reg  <= g;
            blue_reg   <= b;
            last_reg   <= is_last;
            panic_reg  <= q_desc.panic;
            llamp_reg  <= q_desc.left_lamp;
            rlamp_reg  <= q_desc.right_lamp;
            notify_reg <= q_desc.notify;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_index  = index_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last_pixel   = last_reg;
    assign panic_active = panic_reg;
    assign left_lamp    = llamp_reg;
    assign right_lamp   = rlamp_reg;
    assign notify       = notify_reg;

endmodule

>>> src/bike_light_frame_controller_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Beat
// in      | input     | in_valid/in_stall  | one frame tick: time, accel, buttons
// out     | output    | out_valid/out_stall| one pixel of the frame, index 0 upward
// cfg     | input     | cfg_wr_en          | register write, index 0 threshold, 1 timeout
//
// Each tick yields NUM_PIXELS output beats, one per cycle from the pixel counter
// in the back end while out_stall is low and a descriptor is queued.
// The front end takes a tick whenever the queue is not full and queues up to two frame descriptors.
// With the queue empty, a taken tick is queued, then its first pixel is registered at the output.
// in_stall rises when the queue is full; out_stall holds the output register.
// Reset (rst_n low, async) clears queue, control and config state; not slots or pixel data.

module bike_light_frame_controller_top #(
    parameter int NUM_PIXELS   = 20,
    parameter int FLASH_PERIOD = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  blfc_pkg::cfg_index_t                cfg_index,
    input  logic [blfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [blfc_pkg::TIME_W-1:0]         time_ms,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_x,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_y,
    input  logic signed [blfc_pkg::ACCEL_W-1:0] accel_z,
    input  logic                                right_button_n,
    input  logic                                left_button_n,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [blfc_pkg::PIXEL_W-1:0]        pixel_index,
    output logic [blfc_pkg::COLOR_W-1:0]        red,
    output logic [blfc_pkg::COLOR_W-1:0]        green,
    output logic [blfc_pkg::COLOR_W-1:0]        blue,
    output logic                                last_pixel,
    output logic                                panic_active,
    output logic                                left_lamp,
    output logic                                right_lamp,
    output logic [blfc_pkg::NOTIFY_W-1:0]       notify
);
    import blfc_pkg::*;

    frame_desc_t front_desc;
    frame_desc_t head_desc;
    logic        accept, q_full, q_not_empty, q_pop;

    assign in_stall = q_full;
    assign accept = in_valid && !q_full;

    blfc_front #(
        .NUM_PIXELS   (NUM_PIXELS),
        .FLASH_PERIOD (FLASH_PERIOD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .time_ms        (time_ms),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .right_button_n (right_button_n),
        .left_button_n  (left_button_n),
        .desc           (front_desc)
    );

    blfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_desc (front_desc),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    blfc_back #(
        .NUM_PIXELS (NUM_PIXELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_desc       (head_desc),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel),
        .panic_active (panic_active),
        .left_lamp    (left_lamp),
        .right_lamp   (right_lamp),
        .notify       (notify)
    );

endmodule

>>> src/blfc_checker.sv
`timescale 1ns / 1ps

module blfc_checker #(
    parameter int NUM_PIXELS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [blfc_pkg::PIXEL_W-1:0]  pixel_index,
    input  logic                          last_pixel,
    input  logic                          panic_active,
    input  logic [blfc_pkg::NOTIFY_W-1:0] notify
);
    import blfc_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(last_pixel))
        else $error("stalled output beat changed");

    // pixels within a frame count up by one
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_pixel) ##1 out_valid
        |-> pixel_index == $past(pixel_index) + 1'b1)
        else $error("pixel index did not advance");

    // frame-wide status is the same on every pixel
    a_frame_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_pixel) ##1 out_valid
        |-> $stable(panic_active) && $stable(notify))
        else $error("frame status changed inside a frame");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> pixel_index == PIXEL_W'(NUM_PIXELS - 1))
        else $error("last pixel flag on wrong index");

    a_trig_panic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify[NOTIFY_TRIG_BIT] |-> panic_active && !notify[NOTIFY_END_BIT])
        else $error("trigger reported without panic");

endmodule

bind bike_light_frame_controller_top blfc_checker #(
    .NUM_PIXELS (NUM_PIXELS)
) u_blfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_index  (pixel_index),
    .last_pixel   (last_pixel),
    .panic_active (panic_active),
    .notify       (notify)
);

>>> dv/bike_light_frame_controller_top_tb.sv
`timescale 1ns / 1ps

module bike_light_frame_controller_top_tb;

    import blfc_pkg::*;

    localparam int PIXELS    = 20;
    localparam int FLASH_LEN = 16;

    typedef struct {
        logic [TIME_W-1:0]         stamp;
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        logic                      right_n;
        logic                      left_n;
    } tick_t;

    typedef struct {
        logic [PIXEL_W-1:0]  index;
        logic [COLOR_W-1:0]  r;
        logic [COLOR_W-1:0]  g;
        logic [COLOR_W-1:0]  b;
        logic                last;
        logic                panic;
        logic                llamp;
        logic                rlamp;
        logic [NOTIFY_W-1:0] note;
    } pixel_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    cfg_index_t                   cfg_index;
    logic [CFG_DATA_W-1:0]        cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [TIME_W-1:0]            time_ms;
    logic signed [ACCEL_W-1:0]    accel_x;
    logic signed [ACCEL_W-1:0]    accel_y;
    logic signed [ACCEL_W-1:0]    accel_z;
    logic                         right_button_n;
    logic                         left_button_n;
    logic                         out_valid;
    logic                         out_stall;
    logic [PIXEL_W-1:0]           pixel_index;
    logic [COLOR_W-1:0]           red;
    logic [COLOR_W-1:0]           green;
    logic [COLOR_W-1:0]           blue;
    logic                         last_pixel;
    logic                         panic_active;
    logic                         left_lamp;
    logic                         right_lamp;
    logic [NOTIFY_W-1:0]          notify;

    // light controller shadow state
    logic [THR_W-1:0]  thr_mg      = THR_RESET;
    logic [TMO_W-1:0]  tmo_ms      = TMO_RESET;
    logic              panic_on    = 1'b0;
    logic [TIME_W-1:0] panic_t0    = '0;
    logic              r_held      = 1'b0;
    logic              l_held      = 1'b0;
    logic              r_blink     = 1'b0;
    logic              l_blink     = 1'b0;
    int                phase       = 0;
    logic [BAR_W-1:0]  bar_at      = BAR_W'(BAR_LOW);
    logic              bar_down    = 1'b0;
    logic              lamp_l      = 1'b0;
    logic              lamp_r      = 1'b0;

    pixel_t            pending_pixels[$];
    int                mismatches  = 0;
    int                stall_level = 0;
    int                hold_cycles = 0;

    // stimulus walk: rider clock and button levels
    logic [TIME_W-1:0] clock_ms    = '0;
    logic              right_level = 1'b1;
    logic              left_level  = 1'b1;

    bike_light_frame_controller_top #(
        .NUM_PIXELS  (PIXELS),
        .FLASH_PERIOD(FLASH_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .time_ms       (time_ms),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .right_button_n(right_button_n),
        .left_button_n (left_button_n),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_index   (pixel_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_pixel    (last_pixel),
        .panic_active  (panic_active),
        .left_lamp     (left_lamp),
        .right_lamp    (right_lamp),
        .notify        (notify)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [SUM_W-1:0] magnitude(input logic signed [ACCEL_W-1:0] v);
        int w;
        w = v;
        if (w < 0)
        begin
            w = -w;
        end
        return w[SUM_W-1:0];
    endfunction

    // Advances the shadow state by one tick and queues the frame it draws.
    function automatic void render_frame(input tick_t t);
        logic [SUM_W-1:0]    mag;
        logic [TIME_W-1:0]   elapsed;
        logic [NOTIFY_W-1:0] note;
        logic                r_down;
        logic                l_down;
        logic                flash;
        logic [BAR_W-1:0]    bar_draw;
        pixel_t              px;
        mag  = magnitude(t.ax) + magnitude(t.ay) + magnitude(t.az);
        note = '0;
        bar_draw = '0;
        if (mag > thr_mg)
        begin
            panic_on = 1'b1;
            panic_t0 = t.stamp;
            note[NOTIFY_TRIG_BIT] = 1'b1;
        end
        elapsed = t.stamp - panic_t0;
        if (panic_on && elapsed > tmo_ms)
        begin
            panic_on = 1'b0;
            note[NOTIFY_END_BIT] = 1'b1;
        end
        r_down = !t.right_n;
        l_down = !t.left_n;
        if (r_down && !r_held)
        begin
            r_blink = !r_blink;
        end
        if (l_down && !l_held)
        begin
            l_blink = !l_blink;
        end
        r_held = r_down;
        l_held = l_down;
        flash  = phase >= FLASH_LEN / 2;
        if (!panic_on)
        begin
            lamp_l   = l_blink && flash;
            lamp_r   = r_blink && flash;
            bar_draw = bar_at;
            if (!bar_down && bar_at == PIXELS - BAR_MARGIN)
            begin
                bar_down = 1'b1;
            end
            else if (bar_down && bar_at == BAR_LOW)
            begin
                bar_down = 1'b0;
            end
            bar_at = bar_down ? bar_at - 1'b1 : bar_at + 1'b1;
        end
        for (int i = 0; i < PIXELS; i++)
        begin
            px.r = COLOR_OFF;
            px.g = COLOR_OFF;
            px.b = COLOR_OFF;
            if (panic_on)
            begin
                if (flash)
                begin
                    px.r = COLOR_FULL;
                end
            end
            else
            begin
                if ((l_blink && flash && i >= PIXELS - LAMP_SPAN)
                    || (r_blink && flash && i < LAMP_SPAN))
                begin
                    px.r = AMBER_R;
                    px.g = AMBER_G;
                    px.b = AMBER_B;
                end
                if (i == bar_draw || i == bar_draw + 1)
                begin
                    px.r = COLOR_FULL;
                    px.g = COLOR_OFF;
                    px.b = COLOR_OFF;
                end
            end
            px.index = i[PIXEL_W-1:0];
            px.last  = i == PIXELS - 1;
            px.panic = panic_on;
            px.llamp = lamp_l;
            px.rlamp = lamp_r;
            px.note  = note;
            pending_pixels.push_back(px);
        end
        phase = (phase + 1) % FLASH_LEN;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin : pixel_monitor
        pixel_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel beat with none pending: index %0d", pixel_index);
                    mismatches++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_index", want.index, pixel_index);
                    check_field("red", want.r, red);
                    check_field("green", want.g, green);
                    check_field("blue", want.b, blue);
                    check_field("last_pixel", want.last, last_pixel);
                    check_field("panic_active", want.panic, panic_active);
                    check_field("left_lamp", want.llamp, left_lamp);
                    check_field("right_lamp", want.rlamp, right_lamp);
                    check_field("notify", want.note, notify);
                end
            end
        end
    end

    // receiver: alternating stall/free runs, plus a long hold when asked
    initial
    begin : receiver_pacing
        int   run_left;
        logic stalled;
        run_left = 0;
        stalled  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else if (stall_level == 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalled  = !stalled;
                    run_left = stalled ? $urandom_range(1, stall_level == 1 ? 2 : 6)
                                       : $urandom_range(1, stall_level == 1 ? 8 : 3);
                end
                run_left--;
                out_stall <= stalled;
            end
        end
    end

    function automatic tick_t make_tick(input logic [TIME_W-1:0] stamp, input int x,
                                        input int y, input int z, input logic rn,
                                        input logic ln);
        tick_t t;
        t.stamp   = stamp;
        t.ax      = x[ACCEL_W-1:0];
        t.ay      = y[ACCEL_W-1:0];
        t.az      = z[ACCEL_W-1:0];
        t.right_n = rn;
        t.left_n  = ln;
        return t;
    endfunction

    function automatic logic signed [ACCEL_W-1:0] axis_value(input int lo, input int hi,
                                                             input bit mirror);
        int v;
        v = lo + int'($urandom_range(0, hi - lo));
        if (mirror && $urandom_range(0, 1) == 1)
        begin
            v = -v;
        end
        return v[ACCEL_W-1:0];
    endfunction

    // Riding pattern: mostly steady time with jumps, calm motion, occasional shocks and button presses.
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            clock_ms += $urandom_range(1, 200);
        end
        else if (pick < 85 && panic_on)
        begin
            clock_ms = panic_t0 + tmo_ms + $urandom_range(0, 1);
        end
        else if (pick < 95)
        begin
            clock_ms += $urandom_range(0, 2 * tmo_ms + 2);
        end
        else
        begin
            clock_ms = $urandom();
        end
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            t.ax = axis_value(1500, 4000, 1);
            t.ay = axis_value(1500, 4000, 1);
            t.az = axis_value(1500, 4000, 1);
        end
        else if (pick < 25)
        begin
            t.ax = axis_value(-4000, 4000, 0);
            t.ay = axis_value(-4000, 4000, 0);
            t.az = axis_value(-4000, 4000, 0);
        end
        else
        begin
            t.ax = axis_value(0, 300, 1);
            t.ay = axis_value(0, 300, 1);
            t.az = axis_value(700, 1200, 1);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            right_level = !right_level;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            left_level = !left_level;
        end
        t.stamp   = clock_ms;
        t.right_n = right_level;
        t.left_n  = left_level;
        return t;
    endfunction

    // Starts and ends at a falling edge; valid stays high for the caller.
    task automatic send_tick(input tick_t t);
        in_valid       <= 1'b1;
        time_ms        <= t.stamp;
        accel_x        <= t.ax;
        accel_y        <= t.ay;
        accel_z        <= t.az;
        right_button_n <= t.right_n;
        left_button_n  <= t.left_n;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        render_frame(t);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD: thr_mg = val[THR_W-1:0];
            CFG_TIMEOUT:   tmo_ms = val[TMO_W-1:0];
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] thr,
                               input logic [CFG_DATA_W-1:0] tmo);
        wait_drained();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    task automatic test_random_frames(input int count, input int level);
        int burst;
        stall_level = level;
        burst = $urandom_range(1, 10);
        repeat (count)
        begin
            send_tick(random_tick());
            burst--;
            if (burst == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst = $urandom_range(1, 10);
            end
        end
    endtask

    task automatic test_directed_frames();
        stall_level = 0;
        send_tick(make_tick(0, 0, 0, 1000, 1, 1));
        // sum equal to threshold does not trigger
        send_tick(make_tick(10, 1000, 500, 500, 1, 1));
        send_tick(make_tick(20, 0, 0, 0, 0, 1));
        send_tick(make_tick(30, 0, 0, 0, 0, 1));
        send_tick(make_tick(40, 0, 0, 0, 1, 0));
        send_tick(make_tick(50, 0, 0, 0, 1, 1));
        send_tick(make_tick(60, 1001, -500, 500, 1, 1));
        // elapsed equal to timeout holds, one more ms ends
        send_tick(make_tick(5060, 0, 0, 0, 1, 1));
        send_tick(make_tick(5061, 0, 0, 0, 1, 1));
        send_tick(make_tick(5070, 0, 0, 0, 0, 0));
        send_tick(make_tick(5080, 0, 0, 0, 1, 1));
        send_tick(make_tick(5090, 0, 0, 0, 0, 0));
        send_tick(make_tick(5100, 4000, 4000, 4000, 1, 1));
        // retrigger long past timeout: trigger wins, no end
        send_tick(make_tick(20000, -4000, -4000, -4000, 0, 1));
        send_tick(make_tick(32'hFFFF_FF00, 0, 0, 0, 1, 1));
        send_tick(make_tick(32'hFFFF_FF80, 4000, 0, -4000, 1, 0));
        // elapsed measured across the wrap
        send_tick(make_tick(32'h0000_0F00, 0, 0, 0, 1, 1));
        send_tick(make_tick(32'h0000_1309, 0, 0, 0, 1, 1));
        clock_ms = 32'h0000_1309;
    endtask

    task automatic test_config_extremes();
        reconfigure(0, 0);
        stall_level = 0;
        send_tick(make_tick(1000, 0, 0, 0, 1, 1));
        send_tick(make_tick(1000, 0, 1, 0, 1, 1));
        send_tick(make_tick(1000, 0, 0, 0, 1, 1));
        send_tick(make_tick(1001, 0, 0, 0, 1, 1));
        clock_ms = 1001;
        test_random_frames(40, 1);
        reconfigure(12000, 16'hFFFF);
        clock_ms += 5;
        send_tick(make_tick(clock_ms, 4000, -4000, 4000, 1, 1));
        test_random_frames(40, 2);
    endtask

    task automatic test_backpressure();
        stall_level = 0;
        hold_cycles = 200;
        repeat (12) send_tick(random_tick());
        wait_drained();
        repeat (4) send_tick(random_tick());
    endtask

    task automatic test_time_wrap();
        reconfigure(2500, 3000);
        clock_ms = 32'hFFFF_F800;
        test_random_frames(40, 1);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_THRESHOLD;
        cfg_data       = '0;
        in_valid       = 1'b0;
        time_ms        = '0;
        accel_x        = '0;
        accel_y        = '0;
        accel_z        = '0;
        right_button_n = 1'b1;
        left_button_n  = 1'b1;
        out_stall      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_config_extremes();
        reconfigure(THR_RESET, TMO_RESET);
        test_random_frames(110, 1);
        test_backpressure();
        test_time_wrap();
        repeat (3)
        begin
            reconfigure($urandom_range(200, 6000),
                        $urandom_range(0, 1) ? $urandom_range(0, 400)
                                             : $urandom_range(0, 65535));
            test_random_frames(40, 2);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
src/blfc_pkg.sv
src/blfc_front.sv
src/blfc_queue.sv
src/blfc_back.sv
src/bike_light_frame_controller_top.sv
src/blfc_checker.sv
dv/bike_light_frame_controller_top_tb.sv
